// File: src/prg_pkg.sv
// prng range generator package: widths, constants, config and kind codes, unit request types
// shared by the arithmetic unit and the top level; no dependencies
`timescale 1ns / 1ps
package prg_pkg;

  localparam int unsigned WordW = 64;
  localparam int unsigned CntW  = $clog2(WordW);

  localparam logic [WordW-1:0] GoldenStep = 64'h9E3779B97F4A7C15;
  localparam logic [WordW-1:0] MixMulA    = 64'hBF58476D1CE4E5B9;
  localparam logic [WordW-1:0] MixMulB    = 64'h94D049BB133111EB;

  // configuration register indexes
  localparam logic CfgKind = 1'b0;
  localparam logic CfgSeed = 1'b1;

  // generator kinds
  localparam logic GenMix = 1'b0;
  localparam logic GenXor = 1'b1;

  typedef enum logic {
    ALU_MUL,
    ALU_DIV
  } alu_op_e;

  typedef struct packed {
    logic             start;
    logic             flush;
    alu_op_e          op;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [WordW-1:0] res;
  } alu_rsp_t;

endpackage

// File: src/prg_if.sv
// request and response channel interfaces of the prng range generator
// depends on prg_pkg for the word width
`timescale 1ns / 1ps
interface prg_req_if;
  logic                      valid;
  logic                      ready;
  logic [prg_pkg::WordW-1:0] range_low;
  logic [prg_pkg::WordW-1:0] range_high;
  logic                      signed_range;

  modport source (output valid, range_low, range_high, signed_range, input ready);
  modport sink (input valid, range_low, range_high, signed_range, output ready);
endinterface

interface prg_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [prg_pkg::WordW-1:0] value;

  modport source (output valid, value, input ready);
  modport sink (input valid, value, output ready);
endinterface

// File: src/prg_alu.sv
// shared iterative unit: 64x64 low-half multiply (shift-add) and
// 64/64 restoring divide, one bit per cycle over one 65-bit adder; uses prg_pkg
`timescale 1ns / 1ps
module prg_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  prg_pkg::alu_req_t req_i,
  output prg_pkg::alu_rsp_t rsp_o
);

  localparam int unsigned W = prg_pkg::WordW;

  logic                      busy_q, busy_d;
  logic                      done_q, done_d;
  prg_pkg::alu_op_e          op_q, op_d;
  logic [prg_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [W-1:0]              acc_q, acc_d;
  logic [W-1:0]              x_q, x_d;
  logic [W-1:0]              y_q, y_d;

  logic [W:0]   add_a, add_b, rem_sh;
  logic         add_cin;
  logic [W+1:0] sum;

  // operand select for the one adder
  always_comb begin
    rem_sh = {acc_q, x_q[W-1]};
    if (op_q == prg_pkg::ALU_MUL) begin
      add_a   = {1'b0, acc_q};
      add_b   = y_q[0] ? {1'b0, x_q} : '0;
      add_cin = 1'b0;
    end else begin
      add_a   = rem_sh;
      add_b   = ~{1'b0, y_q};
      add_cin = 1'b1;
    end
    sum = {1'b0, add_a} + {1'b0, add_b} + {{(W+1){1'b0}}, add_cin};
  end

  // step sequencing
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    op_d   = op_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    x_d    = x_q;
    y_d    = y_q;
    if (req_i.flush) begin
      busy_d = 1'b0;
    end else if (req_i.start) begin
      busy_d = 1'b1;
      op_d   = req_i.op;
      cnt_d  = '0;
      acc_d  = '0;
      x_d    = req_i.a;
      y_d    = req_i.b;
    end else if (busy_q) begin
      if (op_q == prg_pkg::ALU_MUL) begin
        acc_d = sum[W-1:0];
        x_d   = {x_q[W-2:0], 1'b0};
        y_d   = {1'b0, y_q[W-1:1]};
      end else begin
        acc_d = sum[W+1] ? sum[W-1:0] : rem_sh[W-1:0];
        x_d   = {x_q[W-2:0], sum[W+1]};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == prg_pkg::CntW'(W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      op_q   <= prg_pkg::ALU_MUL;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      op_q   <= op_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    x_q   <= x_d;
    y_q   <= y_d;
  end

  assign rsp_o.done = done_q;
  assign rsp_o.res  = (op_q == prg_pkg::ALU_MUL) ? acc_q : x_q;

`ifndef SYNTHESIS
  a_done_not_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("unit done while still busy");
  a_done_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(done_q) |-> $past(busy_q)) else $error("unit done without a run");
  a_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start && !req_i.flush |=> busy_q) else $error("start not taken");
`endif

endmodule

// File: src/prng_range_generator.sv
// prng range generator top level: sequencer, generator state, config port
// depends on prg_pkg, prg_if and prg_alu
// steps from acceptance to valid result: equal bounds go straight to the
// finish; otherwise range setup (divide then multiply, skipped for the full
// range), each draw (splitmix64: two multiplies; xoroshiro128+: one step),
// check and final divide (check only for the full range), then the result is
// loaded; each rejected draw adds one draw and a check. One item at a time.
// reset: async active low; seeding from seed 0 takes two splitmix64 steps
// with the request channel not ready
`timescale 1ns / 1ps
module prng_range_generator (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  prg_req_if.sink                   req,
  prg_rsp_if.source                 rsp,
  input  logic                      cfg_we_i,
  input  logic                      cfg_index_i,
  input  logic [prg_pkg::WordW-1:0] cfg_data_i
);

  localparam int unsigned W = prg_pkg::WordW;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_PREP = 4'd1;
  localparam logic [3:0] S_BKT  = 4'd2;
  localparam logic [3:0] S_LIM  = 4'd3;
  localparam logic [3:0] S_DRAW = 4'd4;
  localparam logic [3:0] S_MIX1 = 4'd5;
  localparam logic [3:0] S_MIX2 = 4'd6;
  localparam logic [3:0] S_CHK  = 4'd7;
  localparam logic [3:0] S_DIVV = 4'd8;
  localparam logic [3:0] S_FIN  = 4'd9;
  localparam logic [3:0] S_SEED = 4'd10;

  logic [3:0]   state_q, state_d;
  logic         kind_q, kind_d;
  logic         seeding_q, seeding_d;
  logic         have_a_q, have_a_d;
  logic [W-1:0] ctr_q, ctr_d;
  logic [W-1:0] tmp_q, tmp_d;
  logic [W-1:0] wa_q, wa_d;
  logic [W-1:0] wb_q, wb_d;
  logic [W-1:0] lo_q, lo_d, hi_q, hi_d;
  logic         flip_q, flip_d;
  logic [W-1:0] span_q, span_d;
  logic [W-1:0] bkt_q, bkt_d;
  logic [W-1:0] lim_q, lim_d;
  logic [W-1:0] v_q, v_d;
  logic [W-1:0] r_q, r_d;
  logic         ov_q, ov_d;
  logic [W-1:0] oval_q, oval_d;

  prg_pkg::alu_req_t alu_req;
  prg_pkg::alu_rsp_t alu_rsp;

  logic [W-1:0] in_lo, in_hi, ctr_new, z1, z2, mix_out, xb;
  logic         full_rng;

  prg_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  assign req.ready = (state_q == S_IDLE);
  assign rsp.valid = ov_q;
  assign rsp.value = oval_q;

  // bounds after sign flip
  assign in_lo = req.range_low ^ {req.signed_range, {(W-1){1'b0}}};
  assign in_hi = req.range_high ^ {req.signed_range, {(W-1){1'b0}}};

  // splitmix64 pieces around the two multiplies
  assign ctr_new  = (seeding_q ? tmp_q : ctr_q) + prg_pkg::GoldenStep;
  assign z1       = ctr_new ^ (ctr_new >> 30);
  assign z2       = alu_rsp.res ^ (alu_rsp.res >> 27);
  assign mix_out  = alu_rsp.res ^ (alu_rsp.res >> 31);
  assign xb       = wa_q ^ wb_q;
  assign full_rng = (lo_q == '0) && (hi_q == '1);

  // sequencer
  always_comb begin
    state_d   = state_q;
    kind_d    = kind_q;
    seeding_d = seeding_q;
    have_a_d  = have_a_q;
    ctr_d     = ctr_q;
    tmp_d     = tmp_q;
    wa_d      = wa_q;
    wb_d      = wb_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    flip_d    = flip_q;
    span_d    = span_q;
    bkt_d     = bkt_q;
    lim_d     = lim_q;
    v_d       = v_q;
    r_d       = r_q;
    ov_d      = ov_q;
    oval_d    = oval_q;
    alu_req   = '{start: 1'b0, flush: 1'b0, op: prg_pkg::ALU_MUL, a: z1, b: prg_pkg::MixMulA};

    // result handed off
    if (ov_q && rsp.ready) begin
      ov_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (req.valid) begin
          flip_d  = req.signed_range;
          lo_d    = (in_lo > in_hi) ? in_hi : in_lo;
          hi_d    = (in_lo > in_hi) ? in_lo : in_hi;
          state_d = S_PREP;
        end
      end
      S_PREP: begin
        span_d = hi_q - lo_q + 1'b1;
        if (lo_q == hi_q) begin
          r_d     = lo_q;
          state_d = S_FIN;
        end else if (full_rng) begin
          state_d = S_DRAW;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = prg_pkg::ALU_DIV;
          alu_req.a     = '1;
          alu_req.b     = hi_q - lo_q + 1'b1;
          state_d       = S_BKT;
        end
      end
      S_BKT: begin
        if (alu_rsp.done) begin
          bkt_d         = alu_rsp.res;
          alu_req.start = 1'b1;
          alu_req.op    = prg_pkg::ALU_MUL;
          alu_req.a     = alu_rsp.res;
          alu_req.b     = span_q;
          state_d       = S_LIM;
        end
      end
      S_LIM: begin
        if (alu_rsp.done) begin
          lim_d   = alu_rsp.res;
          state_d = S_DRAW;
        end
      end
      S_DRAW, S_SEED: begin
        if (!seeding_q && kind_q == prg_pkg::GenXor) begin
          v_d     = wa_q + wb_q;
          wa_d    = {wa_q[W-56:0], wa_q[W-1:W-55]} ^ xb ^ (xb << 14);
          wb_d    = {xb[W-37:0], xb[W-1:W-36]};
          state_d = S_CHK;
        end else begin
          if (seeding_q) begin
            tmp_d = ctr_new;
          end else begin
            ctr_d = ctr_new;
          end
          alu_req.start = 1'b1;
          state_d       = S_MIX1;
        end
      end
      S_MIX1: begin
        if (alu_rsp.done) begin
          alu_req.start = 1'b1;
          alu_req.a     = z2;
          alu_req.b     = prg_pkg::MixMulB;
          state_d       = S_MIX2;
        end
      end
      S_MIX2: begin
        if (alu_rsp.done) begin
          v_d     = mix_out;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (seeding_q) begin
          if (v_q == '0) begin
            state_d = S_SEED;
          end else if (!have_a_q) begin
            wa_d     = v_q;
            have_a_d = 1'b1;
            state_d  = S_SEED;
          end else begin
            wb_d      = v_q;
            seeding_d = 1'b0;
            state_d   = S_IDLE;
          end
        end else if (full_rng) begin
          r_d     = v_q;
          state_d = S_FIN;
        end else if (v_q >= lim_q) begin
          state_d = S_DRAW;
        end else begin
          alu_req.start = 1'b1;
          alu_req.op    = prg_pkg::ALU_DIV;
          alu_req.a     = v_q;
          alu_req.b     = bkt_q;
          state_d       = S_DIVV;
        end
      end
      S_DIVV: begin
        if (alu_rsp.done) begin
          r_d     = lo_q + alu_rsp.res;
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        if (!ov_q || rsp.ready) begin
          ov_d    = 1'b1;
          oval_d  = r_q ^ {flip_q, {(W-1){1'b0}}};
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // configuration writes; a seed write restarts seeding
    if (cfg_we_i) begin
      if (cfg_index_i == prg_pkg::CfgKind) begin
        kind_d = cfg_data_i[0];
      end else begin
        tmp_d         = cfg_data_i;
        ctr_d         = cfg_data_i;
        seeding_d     = 1'b1;
        have_a_d      = 1'b0;
        alu_req.start = 1'b0;
        alu_req.flush = 1'b1;
        state_d       = S_SEED;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_SEED;
      kind_q    <= prg_pkg::GenXor;
      seeding_q <= 1'b1;
      have_a_q  <= 1'b0;
      ctr_q     <= '0;
      tmp_q     <= '0;
      ov_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      kind_q    <= kind_d;
      seeding_q <= seeding_d;
      have_a_q  <= have_a_d;
      ctr_q     <= ctr_d;
      tmp_q     <= tmp_d;
      ov_q      <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q   <= wa_d;
    wb_q   <= wb_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    flip_q <= flip_d;
    span_q <= span_d;
    bkt_q  <= bkt_d;
    lim_q  <= lim_d;
    v_q    <= v_d;
    r_q    <= r_d;
    oval_q <= oval_d;
  end

`ifndef SYNTHESIS
  a_accept_prep : assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.valid && req.ready && !cfg_we_i |=> state_q == S_PREP)
    else $error("accepted item not started");
  a_load_from_fin : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(ov_q) |-> $past(state_q) == S_FIN)
    else $error("result loaded outside finish");
  a_no_ready_seeding : assert property (@(posedge clk_i) disable iff (!rst_ni)
    seeding_q |-> !req.ready)
    else $error("ready during seeding");
  a_seed_restart : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i && cfg_index_i == prg_pkg::CfgSeed |=> state_q == S_SEED && seeding_q)
    else $error("seed write did not restart seeding");
`endif

endmodule
